FILE: rtl/ip_address_text_formatter_defines.svh
// Assertion macros shared by the checker of the IP address text formatter.
// No dependencies; included by the checker file.
`ifndef IP_ADDRESS_TEXT_FORMATTER_DEFINES_SVH
`define IP_ADDRESS_TEXT_FORMATTER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define IPFMT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define IPFMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ipfmt_pkg.sv
// Types and constants of the IP address text formatter.
// No dependencies; used by the lane, serializer, top level, checker and bench.
`default_nettype none

package ipfmt_pkg;

  localparam int unsigned NUM_LANES      = 8;
  localparam int unsigned CHARS_PER_LANE = 4;
  localparam int unsigned LANE_W         = $clog2(NUM_LANES);
  localparam int unsigned SUB_W          = $clog2(CHARS_PER_LANE);

  // configuration register indexes
  localparam logic CFG_HEX_UPPER  = 1'b0;
  localparam logic CFG_BRACKET_V6 = 1'b1;

  localparam logic [6:0] CH_ZERO  = 7'h30;  // '0'
  localparam logic [6:0] CH_COLON = 7'h3a;  // ':'
  localparam logic [6:0] CH_DOT   = 7'h2e;  // '.'
  localparam logic [6:0] CH_LBRK  = 7'h5b;  // '['
  localparam logic [6:0] CH_RBRK  = 7'h5d;  // ']'
  localparam logic [6:0] CH_A_UP  = 7'h41;  // 'A'
  localparam logic [6:0] CH_A_LO  = 7'h61;  // 'a'
  localparam logic [6:0] CH_F_LO  = 7'h66;  // 'f'

  localparam logic [LANE_W-1:0] LAST_LANE_V6 = LANE_W'(NUM_LANES - 1);
  localparam logic [LANE_W-1:0] LAST_LANE_V4 = LANE_W'(3);

  typedef logic [6:0] char_t;

  // one formatted group or octet, left-justified, last_idx = digit count - 1
  typedef struct packed {
    char_t [CHARS_PER_LANE-1:0] chars;
    logic  [SUB_W-1:0]          last_idx;
  } lane_out_t;

  typedef enum logic [3:0] {
    PH_OPEN  = 4'b0001,
    PH_DIGIT = 4'b0010,
    PH_SEP   = 4'b0100,
    PH_CLOSE = 4'b1000
  } phase_t;

  function automatic char_t hex_char(input logic [3:0] d, input logic upper);
    char_t base;
    base = upper ? CH_A_UP : CH_A_LO;
    if (d >= 4'd10) return base + char_t'(d - 4'd10);
    return CH_ZERO + char_t'(d);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ipfmt_lane.sv
// One formatting lane: a 16-bit group to hex text or an octet to decimal text.
// Depends on ipfmt_pkg.
`default_nettype none

module ipfmt_lane (
  input  wire logic                 is_ipv6,
  input  wire logic                 hex_upper,
  input  wire logic [15:0]          grp,
  output ipfmt_pkg::lane_out_t      lane_o
);

  ipfmt_pkg::char_t [3:0] dig_chars;  // digit chars, index 0 least significant
  logic [1:0]  nlast;
  logic [7:0]  octet;
  logic [1:0]  hund;
  logic [7:0]  rem;
  logic [13:0] prod;
  logic [3:0]  tens;
  logic [6:0]  unit_full;
  logic [3:0]  units;
  logic [1:0]  src;

  always_comb begin
    octet = grp[7:0];
    if (octet >= 8'd200)      hund = 2'd2;
    else if (octet >= 8'd100) hund = 2'd1;
    else                      hund = 2'd0;
    rem = octet - ((hund == 2'd2) ? 8'd200 : (hund == 2'd1) ? 8'd100 : 8'd0);
    // rem < 100, so rem*103 >> 10 equals rem / 10
    prod = 14'(rem[6:0]) * 14'd103;
    tens = prod[13:10];
    unit_full = rem[6:0] - 7'(tens) * 7'd10;
    units = unit_full[3:0];

    if (is_ipv6) begin
      for (int k = 0; k < 4; k++) begin
        dig_chars[k] = ipfmt_pkg::hex_char(grp[4*k +: 4], hex_upper);
      end
      if (grp[15:12] != 4'd0)     nlast = 2'd3;
      else if (grp[11:8] != 4'd0) nlast = 2'd2;
      else if (grp[7:4] != 4'd0)  nlast = 2'd1;
      else                        nlast = 2'd0;
    end else begin
      dig_chars[0] = ipfmt_pkg::CH_ZERO + 7'(units);
      dig_chars[1] = ipfmt_pkg::CH_ZERO + 7'(tens);
      dig_chars[2] = ipfmt_pkg::CH_ZERO + 7'(hund);
      dig_chars[3] = ipfmt_pkg::CH_ZERO;
      if (hund != 2'd0)      nlast = 2'd2;
      else if (tens != 4'd0) nlast = 2'd1;
      else                   nlast = 2'd0;
    end

    // most significant printed digit first
    for (int j = 0; j < 4; j++) begin
      src = nlast - 2'(j);
      lane_o.chars[j] = dig_chars[src];
    end
    lane_o.last_idx = nlast;
  end

endmodule

`default_nettype wire

FILE: rtl/ipfmt_serializer.sv
// Merge stage: holds the lane results of one request and emits one character
// per cycle if not stalled, via an output register. Depends on ipfmt_pkg.
`default_nettype none

module ipfmt_serializer (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire logic                 load_v6,
  input  wire logic                 load_brk,
  input  wire ipfmt_pkg::lane_out_t [ipfmt_pkg::NUM_LANES-1:0] lanes,
  output logic                      take_ok,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [6:0]                out_char,
  output logic                      out_last
);

  localparam int unsigned LW = ipfmt_pkg::LANE_W;
  localparam int unsigned SW = ipfmt_pkg::SUB_W;

  logic                         buf_valid_r;
  ipfmt_pkg::phase_t            ph_r, ph_nxt;
  logic [LW-1:0]                lane_r, lane_nxt;
  logic [SW-1:0]                sub_r, sub_nxt;
  logic                         v6_r;
  logic                         brk_r;
  ipfmt_pkg::lane_out_t [ipfmt_pkg::NUM_LANES-1:0] lanes_r;

  logic                         out_valid_r;
  logic [6:0]                   out_char_r;
  logic                         out_last_r;

  logic                         advance;
  logic                         emit;
  logic                         done;
  logic [6:0]                   cur_char;
  logic                         cur_last;
  logic [LW-1:0]                last_lane;

  always_comb begin
    advance   = !out_valid_r || out_ready;
    emit      = buf_valid_r && advance;
    last_lane = v6_r ? ipfmt_pkg::LAST_LANE_V6 : ipfmt_pkg::LAST_LANE_V4;
    ph_nxt    = ph_r;
    lane_nxt  = lane_r;
    sub_nxt   = sub_r;
    cur_char  = ipfmt_pkg::CH_ZERO;
    cur_last  = 1'b0;
    done      = 1'b0;
    case (ph_r)
      ipfmt_pkg::PH_OPEN: begin
        cur_char = ipfmt_pkg::CH_LBRK;
        ph_nxt   = ipfmt_pkg::PH_DIGIT;
      end
      ipfmt_pkg::PH_DIGIT: begin
        cur_char = lanes_r[lane_r].chars[sub_r];
        if (sub_r == lanes_r[lane_r].last_idx) begin
          if (lane_r == last_lane) begin
            if (brk_r) begin
              ph_nxt = ipfmt_pkg::PH_CLOSE;
            end else begin
              cur_last = 1'b1;
              done     = 1'b1;
            end
          end else begin
            ph_nxt = ipfmt_pkg::PH_SEP;
          end
        end else begin
          sub_nxt = sub_r + SW'(1);
        end
      end
      ipfmt_pkg::PH_SEP: begin
        cur_char = v6_r ? ipfmt_pkg::CH_COLON : ipfmt_pkg::CH_DOT;
        lane_nxt = lane_r + LW'(1);
        sub_nxt  = '0;
        ph_nxt   = ipfmt_pkg::PH_DIGIT;
      end
      ipfmt_pkg::PH_CLOSE: begin
        cur_char = ipfmt_pkg::CH_RBRK;
        cur_last = 1'b1;
        done     = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
    take_ok = !buf_valid_r || (emit && done);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
      ph_r        <= ipfmt_pkg::PH_DIGIT;
      lane_r      <= '0;
      sub_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        buf_valid_r <= 1'b1;
        ph_r        <= (load_v6 && load_brk) ? ipfmt_pkg::PH_OPEN : ipfmt_pkg::PH_DIGIT;
        lane_r      <= '0;
        sub_r       <= '0;
      end else if (emit) begin
        if (done) begin
          buf_valid_r <= 1'b0;
        end else begin
          ph_r   <= ph_nxt;
          lane_r <= lane_nxt;
          sub_r  <= sub_nxt;
        end
      end
      if (advance) begin
        out_valid_r <= buf_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      v6_r    <= load_v6;
      brk_r   <= load_v6 && load_brk;
      lanes_r <= lanes;
    end
    if (advance) begin
      out_char_r <= cur_char;
      out_last_r <= cur_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/ip_address_text_formatter.sv
// IP address to text: IPv4 dotted decimal or IPv6 colon hex, one char per cycle
// while out_ready is high. The first character passes the buffer register and
// then the output register to out_*. A request has 7..15 characters (IPv4) or
// 15..41 (IPv6), all sent through the single output character port.
// The next request is taken in the cycle the last character leaves the buffer.
// Reset (rst_n low, synchronous): clears pending work and both config registers.
`default_nettype none

module ip_address_text_formatter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_is_ipv6,
  input  wire logic [63:0] in_addr_high,
  input  wire logic [63:0] in_addr_low,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [6:0]       out_char_code,
  output logic             out_is_last,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic        cfg_wdata
);

  logic hex_upper_r;
  logic bracket_v6_r;
  logic take_ok;
  logic load;
  ipfmt_pkg::lane_out_t [ipfmt_pkg::NUM_LANES-1:0] lanes;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hex_upper_r  <= 1'b0;
      bracket_v6_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        ipfmt_pkg::CFG_HEX_UPPER:  hex_upper_r  <= cfg_wdata;
        ipfmt_pkg::CFG_BRACKET_V6: bracket_v6_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ready = take_ok;
  assign load     = in_valid && take_ok;

  for (genvar i = 0; i < ipfmt_pkg::NUM_LANES; i++) begin : g_lane
    logic [15:0] grp;
    always_comb begin
      if (in_is_ipv6) begin
        if (i < 4) grp = in_addr_high[63 - 16*(i % 4) -: 16];
        else       grp = in_addr_low[63 - 16*(i % 4) -: 16];
      end else begin
        // lanes 0..3 carry the four octets, the rest are unused
        grp = {8'h00, in_addr_low[31 - 8*(i % 4) -: 8]};
      end
    end
    ipfmt_lane u_lane (
      .is_ipv6   (in_is_ipv6),
      .hex_upper (hex_upper_r),
      .grp       (grp),
      .lane_o    (lanes[i])
    );
  end

  ipfmt_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .load_v6   (in_is_ipv6),
    .load_brk  (bracket_v6_r),
    .lanes     (lanes),
    .take_ok   (take_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char_code),
    .out_last  (out_is_last)
  );

endmodule

`default_nettype wire

FILE: rtl/ipfmt_checker.sv
// Port-level checks for the IP address text formatter, bound to the top level.
// Depends on ip_address_text_formatter_defines.svh and ipfmt_pkg.
`default_nettype none
`include "ip_address_text_formatter_defines.svh"

module ipfmt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [6:0]  out_char_code,
  input wire logic        out_is_last
);

  `IPFMT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_char_code) && $stable(out_is_last),
    "stalled output changed")

  `IPFMT_ASSERT_NOW(a_char_range, clk, rst_n, out_valid,
    out_char_code >= ipfmt_pkg::CH_DOT && out_char_code <= ipfmt_pkg::CH_F_LO,
    "character outside text set")

  // a request's characters leave without gaps
  `IPFMT_ASSERT_NEXT(a_no_gap, clk, rst_n, out_valid && out_ready && !out_is_last,
    out_valid, "gap inside one address text")

  `IPFMT_ASSERT_NOW(a_last_char, clk, rst_n, out_valid && out_is_last,
    out_char_code != ipfmt_pkg::CH_DOT && out_char_code != ipfmt_pkg::CH_COLON &&
    out_char_code != ipfmt_pkg::CH_LBRK,
    "text ends on a separator or opening bracket")

endmodule

bind ip_address_text_formatter ipfmt_checker u_ipfmt_checker (.*);

`default_nettype wire

FILE: test/ip_address_text_formatter_test.sv
// Self-checking bench for ip_address_text_formatter: IPv4/IPv6 text output checked per char.
// Depends on ipfmt_pkg (character codes, char_t) and the formatter RTL; needs no other files.
`default_nettype none

module ip_address_text_formatter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   RANDOM_PHASES  = 6;
  localparam int   PHASE_ITEMS    = 70;

  typedef struct packed {
    ipfmt_pkg::char_t code;
    logic             last;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_is_ipv6;
  logic [63:0] in_addr_high;
  logic [63:0] in_addr_low;
  logic        out_valid;
  logic        out_ready;
  logic [6:0]  out_char_code;
  logic        out_is_last;
  logic        cfg_we;
  logic        cfg_index;
  logic        cfg_wdata;

  // expected characters, oldest first, and the formatter's register copy
  text_char_t text_q[$];
  bit         hex_upper_q;
  bit         bracket_v6_q;

  bit tx_idle_on;
  bit rx_idle_on;
  int rx_stall_left;
  int rx_hold_req;
  int rx_hold_left;

  int errors;
  int chars_checked;
  int addrs_done;
  int v4_sent;
  int v6_sent;

  ip_address_text_formatter dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_is_ipv6   (in_is_ipv6),
    .in_addr_high (in_addr_high),
    .in_addr_low  (in_addr_low),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_code(out_char_code),
    .out_is_last  (out_is_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #4 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic ipfmt_pkg::char_t hex_ascii(input logic [3:0] nib);
    if (nib >= 4'd10) begin
      return ipfmt_pkg::char_t'((hex_upper_q ? ipfmt_pkg::CH_A_UP : ipfmt_pkg::CH_A_LO)
                                + nib - 4'd10);
    end
    return ipfmt_pkg::char_t'(ipfmt_pkg::CH_ZERO + nib);
  endfunction

  function automatic void predict_text(input logic v6, input logic [63:0] hi,
                                       input logic [63:0] lo);
    ipfmt_pkg::char_t line[$];
    logic [15:0]      grp;
    logic [7:0]       oct;
    logic [3:0]       nib;
    int               k, s, hund, tens, ones;
    bit               lead;
    if (v6) begin
      if (bracket_v6_q) line.push_back(ipfmt_pkg::CH_LBRK);
      for (k = 0; k < 8; k++) begin
        grp = (k < 4) ? hi[48 - 16 * k +: 16] : lo[48 - 16 * (k - 4) +: 16];
        if (k > 0) line.push_back(ipfmt_pkg::CH_COLON);
        lead = 1'b1;
        for (s = 3; s > 0; s--) begin
          nib = grp[4 * s +: 4];
          if (nib != 4'd0 || !lead) begin
            line.push_back(hex_ascii(nib));
            lead = 1'b0;
          end
        end
        line.push_back(hex_ascii(grp[3:0]));
      end
      if (bracket_v6_q) line.push_back(ipfmt_pkg::CH_RBRK);
    end else begin
      for (k = 0; k < 4; k++) begin
        oct  = lo[24 - 8 * k +: 8];
        hund = oct / 100;
        tens = (oct % 100) / 10;
        ones = oct % 10;
        if (k > 0) line.push_back(ipfmt_pkg::CH_DOT);
        if (hund != 0) begin
          line.push_back(ipfmt_pkg::char_t'(ipfmt_pkg::CH_ZERO + hund));
          line.push_back(ipfmt_pkg::char_t'(ipfmt_pkg::CH_ZERO + tens));
        end else if (tens != 0) begin
          line.push_back(ipfmt_pkg::char_t'(ipfmt_pkg::CH_ZERO + tens));
        end
        line.push_back(ipfmt_pkg::char_t'(ipfmt_pkg::CH_ZERO + ones));
      end
    end
    for (k = 0; k < line.size(); k++)
      text_q.push_back('{code: line[k], last: (k == line.size() - 1)});
  endfunction

  // offers one address; valid stays high afterwards until the next request or a drain
  task automatic send_addr(input logic v6, input logic [63:0] hi, input logic [63:0] lo);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_is_ipv6   <= v6;
    in_addr_high <= hi;
    in_addr_low  <= lo;
    do @(posedge clk); while (!in_ready);
    predict_text(v6, hi, lo);
    if (v6) v6_sent++;
    else v4_sent++;
  endtask

  task automatic wait_text_drained();
    in_valid <= 1'b0;
    while (text_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input bit upper, input bit brackets);
    cfg_we    <= 1'b1;
    cfg_index <= ipfmt_pkg::CFG_HEX_UPPER;
    cfg_wdata <= upper;
    @(posedge clk);
    hex_upper_q = upper;
    cfg_index <= ipfmt_pkg::CFG_BRACKET_V6;
    cfg_wdata <= brackets;
    @(posedge clk);
    bracket_v6_q = brackets;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rand_group();
    case ($urandom_range(0, 4))
      0:       return 16'h0;
      1:       return 16'($urandom_range(1, 15));
      2:       return 16'($urandom_range(16, 255));
      3:       return 16'($urandom_range(256, 4095));
      default: return 16'($urandom_range(4096, 65535));
    endcase
  endfunction

  function automatic logic [7:0] rand_octet();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'($urandom_range(1, 9));
      2:       return 8'($urandom_range(10, 99));
      default: return 8'($urandom_range(100, 255));
    endcase
  endfunction

  task automatic send_random_addr();
    logic [63:0] hi, lo;
    logic        v6;
    v6 = 1'($urandom_range(0, 1));
    hi = {$urandom(), $urandom()};
    lo = {$urandom(), $urandom()};
    // most addresses get varied digit counts, the rest stay fully random
    if ($urandom_range(0, 9) != 0) begin
      if (v6) begin
        hi = {rand_group(), rand_group(), rand_group(), rand_group()};
        lo = {rand_group(), rand_group(), rand_group(), rand_group()};
      end else begin
        lo[31:0] = {rand_octet(), rand_octet(), rand_octet(), rand_octet()};
      end
    end
    send_addr(v6, hi, lo);
  endtask

  task automatic test_ipv4_directed();
    send_addr(1'b0, 64'h0, 64'h0);
    send_addr(1'b0, '1, '1);
    send_addr(1'b0, 64'h0123_4567_89ab_cdef, 64'h0000_0000_0116_6409);
    send_addr(1'b0, 64'h0, 64'hdead_beef_0a00_63c8);
    send_addr(1'b0, 64'h0, 64'h0000_0000_6409_0a01);
    wait_text_drained();
  endtask

  task automatic test_ipv6_directed();
    send_addr(1'b1, 64'h0, 64'h0);
    send_addr(1'b1, '1, '1);
    send_addr(1'b1, 64'h0001_0010_0100_1000, 64'h000a_00bc_0def_abcd);
    send_addr(1'b1, 64'hfe80_0000_0000_0000, 64'h0202_b3ff_fe1e_8329);
    wait_text_drained();
  endtask

  task automatic test_config_directed();
    set_config(1'b1, 1'b1);
    send_addr(1'b1, '1, '1);
    send_addr(1'b1, 64'h0001_0010_0100_1000, 64'h000a_00bc_0def_abcd);
    // brackets must not touch IPv4 text
    send_addr(1'b0, '1, '1);
    send_addr(1'b0, 64'h0, 64'h0);
    wait_text_drained();
    set_config(1'b0, 1'b1);
    send_addr(1'b1, 64'h0, 64'h0);
    send_addr(1'b1, 64'h2001_0db8_85a3_0000, 64'h0000_8a2e_0370_7334);
    wait_text_drained();
    set_config(1'b1, 1'b0);
    send_addr(1'b1, 64'habcd_ef01_0fed_00cb, 64'h000f_00e0_0d00_c000);
    send_addr(1'b0, 64'h0, 64'h0000_0000_c0a8_0001);
    wait_text_drained();
  endtask

  task automatic test_random_traffic();
    int phase, n;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase < 4) set_config(phase[0], phase[1]);
      else set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      // one stretch with no idling on either side
      tx_idle_on = (phase != 2) && ($urandom_range(0, 3) != 0 || phase == 0);
      rx_idle_on = (phase != 2) && ($urandom_range(0, 3) != 0 || phase == 0);
      for (n = 0; n < PHASE_ITEMS; n++) send_random_addr();
      wait_text_drained();
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    int n;
    set_config(1'b0, 1'b1);
    tx_idle_on  = 1'b0;
    rx_hold_req = 300;
    for (n = 0; n < 6; n++) send_random_addr();
    tx_idle_on = 1'b1;
    wait_text_drained();
  endtask

  // receiver: random stalls plus the long hold-off asked for by the pressure test
  always @(posedge clk) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_ready <= 1'b0;
      rx_hold_left--;
    end else if (rx_stall_left > 0) begin
      out_ready <= 1'b0;
      rx_stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (rx_idle_on && $urandom_range(0, 3) == 0) rx_stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && out_valid && out_ready) begin
      if (text_q.size() == 0) begin
        $display("%0t: unexpected char: expected none, actual code %h last %b",
                 $time, out_char_code, out_is_last);
        errors++;
      end else begin
        want = text_q.pop_front();
        if (want.code !== out_char_code) begin
          $display("%0t: char_code mismatch: expected %h, actual %h",
                   $time, want.code, out_char_code);
          errors++;
        end
        if (want.last !== out_is_last) begin
          $display("%0t: is_last mismatch: expected %b, actual %b",
                   $time, want.last, out_is_last);
          errors++;
        end
        chars_checked++;
        if (want.last) addrs_done++;
      end
    end
  end

  initial begin
    #(50_000_000);
    $display("%0t: timeout with %0d chars still expected", $time, text_q.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_is_ipv6   <= 1'b0;
    in_addr_high <= '0;
    in_addr_low  <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= ipfmt_pkg::CFG_HEX_UPPER;
    cfg_wdata    <= 1'b0;
    hex_upper_q  = 1'b0;
    bracket_v6_q = 1'b0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_ipv4_directed();
    test_ipv6_directed();
    test_config_directed();
    test_random_traffic();
    test_output_backpressure();

    if (text_q.size() > 0) begin
      $display("%0t: %0d expected chars never arrived", $time, text_q.size());
      errors++;
    end
    $display("Covered %0d IPv4 and %0d IPv6 requests, %0d addresses, %0d chars checked,",
             v4_sent, v6_sent, addrs_done, chars_checked);
    $display("all four case/bracket settings, random stalls and a long output hold-off.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/ipfmt_pkg.sv
rtl/ipfmt_lane.sv
rtl/ipfmt_serializer.sv
rtl/ip_address_text_formatter.sv
rtl/ipfmt_checker.sv
test/ip_address_text_formatter_test.sv
